### hw/rtl/kwl_pkg.sv
// ----------------------------------------------------------------------------
// kwl_pkg: shared definitions of the keyword lexer
// Token kinds, word types, sizing constants and the keyword character table.
// ----------------------------------------------------------------------------
`default_nettype none

package kwl_pkg;

	localparam int MAX_WORD_LEN = 255;
	localparam int POS_BITS     = 16;
	localparam int LEN_BITS     = $clog2(MAX_WORD_LEN + 1);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [2:0] KIND_ASSIGN  = 3'd0;
	localparam logic [2:0] KIND_COLON   = 3'd1;
	localparam logic [2:0] KIND_END     = 3'd2;
	localparam logic [2:0] KIND_INT     = 3'd3;
	localparam logic [2:0] KIND_INPUT   = 3'd4;
	localparam logic [2:0] KIND_OUTPUT  = 3'd5;
	localparam logic [2:0] KIND_IDENT   = 3'd6;
	localparam logic [2:0] KIND_INVALID = 3'd7;

	localparam logic [7:0] CH_ASSIGN = 8'h3D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam int NUM_KW = 3;
	localparam logic [LEN_BITS-1:0] KW_LEN [NUM_KW] = '{
		LEN_BITS'(3), LEN_BITS'(5), LEN_BITS'(6)
	};

	typedef struct packed {
		logic [7:0] ch;
		logic       at_end;
	} char_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] start_pos;
		logic [7:0]  length;
		logic [7:0]  single_byte;
		logic        truncated;
		logic        last;
	} tok_t;

	// Character idx of keyword kw: 0 int, 1 input, 2 output.
	function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] idx);
		logic [7:0] c;
		case ({kw, idx})
			5'b00_000: c = "i";
			5'b00_001: c = "n";
			5'b00_010: c = "t";
			5'b01_000: c = "i";
			5'b01_001: c = "n";
			5'b01_010: c = "p";
			5'b01_011: c = "u";
			5'b01_100: c = "t";
			5'b10_000: c = "o";
			5'b10_001: c = "u";
			5'b10_010: c = "t";
			5'b10_011: c = "p";
			5'b10_100: c = "u";
			5'b10_101: c = "t";
			default:   c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic [15:0] pos16(input logic [POS_BITS-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return w[15:0];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/kwl_if.sv
// ----------------------------------------------------------------------------
// kwl_if: stream channels of the keyword lexer
// Valid/ready channels for source characters and for tokens.
// ----------------------------------------------------------------------------
`default_nettype none

interface kwl_char_if import kwl_pkg::*; ();
	logic  valid;
	logic  ready;
	char_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface kwl_tok_if import kwl_pkg::*; ();
	logic valid;
	logic ready;
	tok_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/keyword_lexer_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// keyword_lexer_tokenizer_unit: streaming lexer with keyword match
// Turns a byte stream into assign, colon, end, keyword, identifier and
// invalid tokens that carry start position and length.
// ----------------------------------------------------------------------------
// The block accepts one character word per cycle unless it stalls. Each word
// is held in an input register until the queue has room for its tokens, then
// classified against the word state in a single pass; its zero, one or two
// tokens go into a four-entry output queue that hands out one token word per
// cycle while the token side is ready. An input word is taken every cycle as
// long as the queue has room for its tokens, so throughput is one byte per
// cycle except where the token side stalls or where items that close a word
// and yield two tokens outrun the drain. The input register feeds the queue.
`default_nettype none

module keyword_lexer_tokenizer_unit import kwl_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	kwl_char_if.sink     chars,
	kwl_tok_if.source    tokens
);

	// Input register.
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       end_s1;

	// Word state.
	logic                in_word_q;
	logic [POS_BITS-1:0] word_start_q;
	logic [LEN_BITS-1:0] word_len_q;
	logic                word_over_q;
	logic [NUM_KW-1:0]   kw_alive_q;
	logic [POS_BITS-1:0] byte_pos_q;

	// Output queue.
	tok_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	logic               fire;
	logic               pop;
	logic [1:0]         n_tok;
	tok_t               tok0;
	tok_t               tok1;
	tok_t               word_tok;
	logic               letter;

	logic                in_word_d;
	logic [POS_BITS-1:0] word_start_d;
	logic [LEN_BITS-1:0] word_len_d;
	logic                word_over_d;
	logic [NUM_KW-1:0]   kw_alive_d;
	logic [POS_BITS-1:0] byte_pos_d;

	logic [LEN_BITS-1:0] eff_len;
	logic [NUM_KW-1:0]   eff_alive;
	logic                eff_over;

	assign pop          = tokens.valid && tokens.ready;
	assign fire         = valid_s1 && ((FIFO_CW'(FIFO_DEPTH) - count_q) >= FIFO_CW'(n_tok));
	assign chars.ready  = !valid_s1 || fire;
	assign tokens.valid = (count_q != '0);
	assign tokens.data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1  <= chars.data.ch;
			end_s1 <= chars.data.at_end;
		end
	end

	// Token for the word being closed, built from the current state.
	always_comb begin
		word_tok = '0;
		word_tok.kind = KIND_IDENT;
		word_tok.start_pos = pos16(word_start_q);
		word_tok.length = (32'(word_len_q) > 32'd255) ? 8'hFF : 8'(word_len_q);
		word_tok.truncated = word_over_q || (32'(word_len_q) > 32'd255);
		for (int i = 0; i < NUM_KW; i++) begin
			if (kw_alive_q[i] && !word_over_q && (word_len_q == KW_LEN[i])) begin
				word_tok.kind = KIND_INT + 3'(i);
			end
		end
	end

	always_comb begin
		letter       = is_letter(ch_s1) && !end_s1;
		eff_len      = in_word_q ? word_len_q : '0;
		eff_alive    = in_word_q ? kw_alive_q : '1;
		eff_over     = in_word_q && word_over_q;

		in_word_d    = in_word_q;
		word_start_d = word_start_q;
		word_len_d   = word_len_q;
		word_over_d  = word_over_q;
		kw_alive_d   = kw_alive_q;
		byte_pos_d   = byte_pos_q;

		n_tok = 2'd0;
		tok0  = '0;
		tok1  = '0;

		if (end_s1) begin
			if (in_word_q) begin
				tok0 = word_tok;
				tok1 = '{kind: KIND_END, start_pos: pos16(byte_pos_q), length: 8'd0,
					single_byte: 8'd0, truncated: 1'b0, last: 1'b1};
				n_tok = 2'd2;
			end else begin
				tok0 = '{kind: KIND_END, start_pos: pos16(byte_pos_q), length: 8'd0,
					single_byte: 8'd0, truncated: 1'b0, last: 1'b1};
				n_tok = 2'd1;
			end
			in_word_d   = 1'b0;
			word_len_d  = '0;
			word_over_d = 1'b0;
			kw_alive_d  = '1;
		end else if (letter) begin
			in_word_d = 1'b1;
			if (!in_word_q) begin
				word_start_d = byte_pos_q;
			end
			// A keyword stays alive while every byte so far matches it.
			for (int i = 0; i < NUM_KW; i++) begin
				kw_alive_d[i] = eff_alive[i] && (eff_len < KW_LEN[i])
					&& (kw_char(2'(i), eff_len[2:0]) == ch_s1);
			end
			if (32'(eff_len) < 32'(MAX_WORD_LEN)) begin
				word_len_d  = eff_len + LEN_BITS'(1);
				word_over_d = eff_over;
			end else begin
				word_len_d  = eff_len;
				word_over_d = 1'b1;
			end
			byte_pos_d = byte_pos_q + POS_BITS'(1);
		end else begin
			tok1 = '{kind: KIND_INVALID, start_pos: pos16(byte_pos_q), length: 8'd1,
				single_byte: ch_s1, truncated: 1'b0, last: 1'b1};
			if (ch_s1 == CH_ASSIGN) begin
				tok1.kind = KIND_ASSIGN;
			end else if (ch_s1 == CH_COLON) begin
				tok1.kind = KIND_COLON;
			end
			if (in_word_q) begin
				tok0 = word_tok;
				if (is_blank(ch_s1)) begin
					tok0.last = 1'b1;
					n_tok = 2'd1;
				end else begin
					n_tok = 2'd2;
				end
			end else begin
				tok0  = tok1;
				n_tok = is_blank(ch_s1) ? 2'd0 : 2'd1;
			end
			in_word_d   = 1'b0;
			word_len_d  = '0;
			word_over_d = 1'b0;
			kw_alive_d  = '1;
			byte_pos_d  = byte_pos_q + POS_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q    <= 1'b0;
			word_start_q <= '0;
			word_len_q   <= '0;
			word_over_q  <= 1'b0;
			kw_alive_q   <= '1;
			byte_pos_q   <= '0;
		end else if (fire) begin
			in_word_q    <= in_word_d;
			word_start_q <= word_start_d;
			word_len_q   <= word_len_d;
			word_over_q  <= word_over_d;
			kw_alive_q   <= kw_alive_d;
			byte_pos_q   <= byte_pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (fire) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_tok);
			end
			count_q <= count_q + (fire ? FIFO_CW'(n_tok) : '0) - FIFO_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (n_tok != 2'd0)) begin
			fifo_q[wr_ptr_q] <= tok0;
		end
		if (fire && (n_tok == 2'd2)) begin
			fifo_q[wr_ptr_q + FIFO_AW'(1)] <= tok1;
		end
	end

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("token queue overflow");

	a_letter_opens_word: assert property (@(posedge clk) disable iff (!arst_n)
		fire && letter |=> in_word_q && (word_len_q != '0))
		else $error("letter did not leave an open word");

	a_end_closes_word: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_s1 |=> !in_word_q && $stable(byte_pos_q))
		else $error("end marker left word open or moved position");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(word_len_q) <= 32'(MAX_WORD_LEN))
		else $error("word length beyond maximum");

	a_letter_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		fire && letter && !pop |=> $stable(count_q))
		else $error("letter produced a token");

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of keyword_lexer_tokenizer_unit
// A fixed table of characters opens the run. Random phrases follow: keywords,
// near misses, plain words, symbols, noise and end markers; then a hold-off
// that fills the token queue, a word past the length limit and more phrases.
// The phases vary the amount of idling on the character and token sides.
// Every token word is checked field by field against an in-bench lexer or a typed-in table row.
// ----------------------------------------------------------------------------

module tb;
	import kwl_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int DRAIN_LIMIT   = 20_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic [7:0] ch;
		logic       at_end;
		logic       typed;
		tok_t       want;
	} dir_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	kwl_char_if char_bus();
	kwl_tok_if  token_bus();

	keyword_lexer_tokenizer_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (char_bus),
		.tokens (token_bus)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Lexer state kept by the bench.
	logic                in_word;
	logic [POS_BITS-1:0] word_start;
	int                  word_len;
	logic                word_over;
	logic [2:0]          kw_alive;
	logic [POS_BITS-1:0] byte_pos;

	string      kw_spell [3] = '{"int", "input", "output"};
	logic [2:0] kw_kind  [3] = '{KIND_INT, KIND_INPUT, KIND_OUTPUT};

	tok_t expected_tokens [$];

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned hold_len      = 0;
	int unsigned hold_tag      = 0;

	int items_sent      = 0;
	int tokens_checked  = 0;
	int mismatches      = 0;
	int longest_word    = 0;
	int truncated_words = 0;
	int in_stall_cycles = 0;

	// Expected results are typed in only where they can be read at a glance.
	dir_row_t rows [30] = '{
		'{8'h00,     1'b1, 1'b1, '{KIND_END,     16'd0, 8'd0, 8'h00,     1'b0, 1'b1}},
		'{8'h00,     1'b0, 1'b1, '{KIND_INVALID, 16'd0, 8'd1, 8'h00,     1'b0, 1'b1}},
		'{CH_ASSIGN, 1'b0, 1'b1, '{KIND_ASSIGN,  16'd1, 8'd1, CH_ASSIGN, 1'b0, 1'b1}},
		'{CH_COLON,  1'b0, 1'b1, '{KIND_COLON,   16'd2, 8'd1, CH_COLON,  1'b0, 1'b1}},
		'{8'hFF,     1'b0, 1'b1, '{KIND_INVALID, 16'd3, 8'd1, 8'hFF,     1'b0, 1'b1}},
		'{CH_SPACE,  1'b0, 1'b0, '0},
		'{CH_TAB,    1'b0, 1'b0, '0},
		'{CH_LF,     1'b0, 1'b0, '0},
		'{CH_CR,     1'b0, 1'b0, '0},
		'{"i",       1'b0, 1'b0, '0},
		'{"n",       1'b0, 1'b0, '0},
		'{"t",       1'b0, 1'b0, '0},
		'{CH_COLON,  1'b0, 1'b0, '0},
		'{"i",       1'b0, 1'b0, '0},
		'{"n",       1'b0, 1'b0, '0},
		'{"p",       1'b0, 1'b0, '0},
		'{"u",       1'b0, 1'b0, '0},
		'{"t",       1'b0, 1'b0, '0},
		'{CH_LF,     1'b0, 1'b0, '0},
		'{"o",       1'b0, 1'b0, '0},
		'{"u",       1'b0, 1'b0, '0},
		'{"t",       1'b0, 1'b0, '0},
		'{"p",       1'b0, 1'b0, '0},
		'{"u",       1'b0, 1'b0, '0},
		'{"t",       1'b0, 1'b0, '0},
		'{8'h00,     1'b1, 1'b0, '0},
		'{"A",       1'b1, 1'b1, '{KIND_END,     16'd24, 8'd0, 8'h00,    1'b0, 1'b1}},
		'{"A",       1'b0, 1'b0, '0},
		'{"z",       1'b0, 1'b0, '0},
		'{"@",       1'b0, 1'b0, '0}
	};

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic tok_t make_tok(input logic [2:0] kind, input logic [POS_BITS-1:0] pos,
			input logic [7:0] len, input logic [7:0] b, input logic trunc);
		tok_t t;
		t.kind        = kind;
		t.start_pos   = 16'(pos);
		t.length      = len;
		t.single_byte = b;
		t.truncated   = trunc;
		t.last        = 1'b0;
		return t;
	endfunction

	function automatic void close_word();
		logic [2:0] kind;
		kind = KIND_IDENT;
		for (int i = 0; i < 3; i++)
			if (kind == KIND_IDENT && kw_alive[i] && !word_over && word_len == kw_spell[i].len())
				kind = kw_kind[i];
		expected_tokens.push_back(make_tok(kind, word_start, 8'(word_len), 8'h00, word_over));
		if (word_len > longest_word)
			longest_word = word_len;
		if (word_over)
			truncated_words++;
		in_word   = 1'b0;
		word_len  = 0;
		word_over = 1'b0;
		kw_alive  = 3'b111;
	endfunction

	// Advances the bench lexer by one character word and queues its tokens.
	function automatic int lex_step(input logic [7:0] c, input logic e);
		int n0;
		n0 = expected_tokens.size();
		if (e) begin
			if (in_word)
				close_word();
			expected_tokens.push_back(make_tok(KIND_END, byte_pos, 8'd0, 8'h00, 1'b0));
		end else begin
			if (is_alpha(c)) begin
				if (!in_word) begin
					in_word    = 1'b1;
					word_start = byte_pos;
					word_len   = 0;
					word_over  = 1'b0;
					kw_alive   = 3'b111;
				end
				for (int i = 0; i < 3; i++)
					if (word_len >= kw_spell[i].len() || kw_spell[i].getc(word_len) != c)
						kw_alive[i] = 1'b0;
				if (word_len < MAX_WORD_LEN)
					word_len++;
				else
					word_over = 1'b1;
			end else begin
				if (in_word)
					close_word();
				case (c)
					CH_ASSIGN: expected_tokens.push_back(make_tok(KIND_ASSIGN, byte_pos, 8'd1, c, 1'b0));
					CH_COLON:  expected_tokens.push_back(make_tok(KIND_COLON, byte_pos, 8'd1, c, 1'b0));
					CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
					default:   expected_tokens.push_back(make_tok(KIND_INVALID, byte_pos, 8'd1, c, 1'b0));
				endcase
			end
			byte_pos++;
		end
		if (expected_tokens.size() > n0)
			expected_tokens[$].last = 1'b1;
		return expected_tokens.size() - n0;
	endfunction

	task automatic drive_char(input logic [7:0] c, input logic e);
		char_t w;
		w.ch     = c;
		w.at_end = e;
		while ($urandom_range(99) < send_idle_pct) begin
			char_bus.valid <= 1'b0;
			@(posedge clk);
		end
		char_bus.valid <= 1'b1;
		char_bus.data  <= w;
		do @(posedge clk); while (char_bus.ready !== 1'b1);
	endtask

	task automatic send_char(input logic [7:0] c, input logic e);
		void'(lex_step(c, e));
		items_sent++;
		drive_char(c, e);
	endtask

	function automatic logic [7:0] any_letter();
		if ($urandom_range(1))
			return 8'("a" + $urandom_range(25));
		return 8'("A" + $urandom_range(25));
	endfunction

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s.getc(i), 1'b0);
	endtask

	task automatic send_run(input int n);
		for (int i = 0; i < n; i++)
			send_char(any_letter(), 1'b0);
	endtask

	task automatic send_near_miss();
		string s;
		int    cut;
		s = kw_spell[$urandom_range(2)];
		case ($urandom_range(3))
			0: begin
				cut = $urandom_range(s.len() - 1, 1);
				for (int i = 0; i < cut; i++)
					send_char(s.getc(i), 1'b0);
			end
			1: begin
				send_text(s);
				send_char(any_letter(), 1'b0);
			end
			2: begin
				s.putc($urandom_range(s.len() - 1), any_letter());
				send_text(s);
			end
			default: begin
				s.putc(0, s.getc(0) - 8'h20);
				send_text(s);
			end
		endcase
	endtask

	task automatic send_delim();
		logic [7:0] b;
		case ($urandom_range(9))
			0: send_char(CH_SPACE, 1'b0);
			1: send_char(CH_TAB, 1'b0);
			2: send_char(CH_LF, 1'b0);
			3: send_char(CH_CR, 1'b0);
			4: send_char(CH_ASSIGN, 1'b0);
			5: send_char(CH_COLON, 1'b0);
			6: send_char(8'($urandom_range(255)), 1'b1);
			7, 8: begin
				do b = 8'($urandom_range(255)); while (is_alpha(b));
				send_char(b, 1'b0);
			end
			// Otherwise the next phrase runs on into this word.
			default: ;
		endcase
	endtask

	task automatic send_phrase();
		int         pick;
		logic [7:0] b;
		pick = $urandom_range(99);
		if (pick < 12) begin
			send_char(8'($urandom_range(255)), $urandom_range(15) == 0);
		end else if (pick < 30) begin
			send_text(kw_spell[$urandom_range(2)]);
			send_delim();
		end else if (pick < 48) begin
			send_near_miss();
			send_delim();
		end else if (pick < 66) begin
			send_run($urandom_range(8, 1));
			send_delim();
		end else if (pick < 80) begin
			send_char($urandom_range(1) ? CH_ASSIGN : CH_COLON, 1'b0);
		end else if (pick < 88) begin
			send_delim();
		end else if (pick < 94) begin
			send_char(8'($urandom_range(255)), 1'b1);
		end else begin
			do b = 8'($urandom_range(255)); while (is_alpha(b));
			send_char(b, 1'b0);
		end
	endtask

	task automatic run_phase(input int unsigned idle, input int unsigned stall, input int count);
		int target;
		send_idle_pct = idle;
		stall_pct     = stall;
		target        = items_sent + count;
		while (items_sent < target)
			send_phrase();
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: token %0d %s mismatch: expected %h, got %h",
				$time, tokens_checked, name, want, got);
			mismatches++;
		end
	endtask

	// The token side counts its own hold-off, so a long stall does not tie up the sender.
	initial begin : token_sink
		int unsigned hold_seen;
		int unsigned hold_left;
		hold_seen       = 0;
		hold_left       = 0;
		token_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_tag != hold_seen) begin
				hold_seen = hold_tag;
				hold_left = hold_len;
			end
			if (hold_left != 0) begin
				hold_left--;
				token_bus.ready <= 1'b0;
			end else begin
				token_bus.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin : token_monitor
		tok_t want;
		tok_t got;
		if (arst_n && char_bus.valid === 1'b1 && char_bus.ready !== 1'b1)
			in_stall_cycles++;
		if (arst_n && token_bus.valid === 1'b1 && token_bus.ready === 1'b1) begin
			got = token_bus.data;
			if (expected_tokens.size() == 0) begin
				$display("%0t ns: unexpected token: kind %0d pos %0d len %0d byte %h trunc %b last %b",
					$time, got.kind, got.start_pos, got.length, got.single_byte, got.truncated,
					got.last);
				mismatches++;
			end else begin
				want = expected_tokens.pop_front();
				check_field("kind", 16'(want.kind), 16'(got.kind));
				check_field("start_pos", want.start_pos, got.start_pos);
				check_field("length", 16'(want.length), 16'(got.length));
				check_field("single_byte", 16'(want.single_byte), 16'(got.single_byte));
				check_field("truncated", 16'(want.truncated), 16'(got.truncated));
				check_field("last", 16'(want.last), 16'(got.last));
			end
			tokens_checked++;
		end
	end

	initial begin : watchdog
		for (int n_cyc = 0; n_cyc < CYCLE_LIMIT; n_cyc++)
			@(posedge clk);
		$display("%0t ns: run exceeded %0d cycles, %0d tokens still due",
			$time, CYCLE_LIMIT, expected_tokens.size());
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		int n;
		char_bus.valid = 1'b0;
		char_bus.data  = '0;
		in_word        = 1'b0;
		word_start     = '0;
		word_len       = 0;
		word_over      = 1'b0;
		kw_alive       = 3'b111;
		byte_pos       = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r]) begin
			n = lex_step(rows[r].ch, rows[r].at_end);
			if (rows[r].typed) begin
				repeat (n) void'(expected_tokens.pop_back());
				expected_tokens.push_back(rows[r].want);
			end
			items_sent++;
			drive_char(rows[r].ch, rows[r].at_end);
		end

		run_phase(0, 0, 140);
		run_phase(68, 0, 140);
		run_phase(0, 68, 140);
		run_phase(12, 12, 120);

		// Hold the token side off while symbols keep coming, so the queue fills
		// and the character side stalls; then wait for every token to drain.
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_len      = HOLD_CYCLES;
		hold_tag++;
		for (int i = 0; i < 60; i++)
			send_char(i[0] ? CH_COLON : CH_ASSIGN, 1'b0);
		char_bus.valid <= 1'b0;
		do @(posedge clk); while (expected_tokens.size() != 0);

		// A word one letter beyond the length limit, closed by a symbol.
		send_idle_pct = 12;
		stall_pct     = 12;
		send_run(MAX_WORD_LEN + 1);
		send_char(CH_ASSIGN, 1'b0);
		send_char(8'h00, 1'b1);

		send_idle_pct = 0;
		stall_pct     = 0;
		send_text("output");
		send_char(CH_ASSIGN, 1'b0);
		send_text("in");
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);
		run_phase(12, 12, 40);

		send_idle_pct = 0;
		stall_pct     = 0;
		char_bus.valid <= 1'b0;
		for (int w = 0; w < DRAIN_LIMIT && expected_tokens.size() != 0; w++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_tokens.size() != 0)
			$display("%0t ns: %0d expected tokens never arrived", $time, expected_tokens.size());

		$display("Sent %0d character words; checked %0d tokens; input stalled %0d cycles.",
			items_sent, tokens_checked, in_stall_cycles);
		$display("Longest word %0d, %0d truncated words.", longest_word, truncated_words);
		if (mismatches == 0 && expected_tokens.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
